// File: rtl/core/spdp_pkg.sv
// ----------------------------------------------------------------------------
// spdp_pkg
// Types, codes and constants shared by the sample player modules.
// ----------------------------------------------------------------------------
package spdp_pkg;

  localparam int SAMPLE_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);

  localparam int LEN_W    = 13;
  localparam int PERIOD_W = 17;
  localparam int POS_W    = 13;
  localparam int LEVEL_W  = 12;
  localparam int SMP_W    = 8;

  // The queue depth must be a power of two; pointers wrap naturally.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Action codes of an input item.
  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_CMD      = 2'd1;
  localparam logic [1:0] ACT_LOAD_DAC = 2'd2;
  localparam logic [1:0] ACT_LOAD_PWM = 2'd3;

  // Command characters.
  localparam logic [7:0] CMD_DAC     = 8'h31;
  localparam logic [7:0] CMD_PWM     = 8'h32;
  localparam logic [7:0] CMD_STOP_LO = 8'h73;
  localparam logic [7:0] CMD_STOP_UP = 8'h53;

  // Player modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_DAC  = 2'd1;
  localparam logic [1:0] MODE_PWM  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DAC_LENGTH     = 2'd0;
  localparam logic [1:0] REG_PWM_LENGTH     = 2'd1;
  localparam logic [1:0] REG_CARRIER_PERIOD = 2'd2;

  localparam logic [LEVEL_W-1:0] DAC_PARK = 12'd2048;
  localparam logic [SMP_W-1:0]   SMP_MID  = 8'd128;
  localparam logic [SMP_W-1:0]   SMP_MAX  = 8'd255;
  localparam logic [SMP_W-1:0]   SMP_MIN  = 8'd0;
  localparam logic [SMP_W-1:0]   SMP_HI   = 8'd192;
  localparam logic [SMP_W-1:0]   SMP_LO   = 8'd64;

  // Division by 255 as multiplication by 33686019, just over 2^33 / 255; exact for
  // every dividend below 2^25.
  localparam int              PROD_W      = SMP_W + PERIOD_W;
  localparam int              RECIP_W     = 26;
  localparam int              RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP_255 = 26'd33686019;
  localparam int              SCALED_W    = PROD_W + RECIP_W;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_PLAY_DAC,
    OP_PLAY_PWM,
    OP_STOP,
    OP_LOAD_DAC,
    OP_LOAD_PWM
  } op_t;

  typedef enum logic [1:0] {
    LVL_KEEP,
    LVL_DAC_SAMPLE,
    LVL_PWM_SAMPLE,
    LVL_PARK
  } lvl_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [SMP_W-1:0]   sample;
  } q_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]    dac_length;
    logic [LEN_W-1:0]    pwm_length;
    logic [PERIOD_W-1:0] carrier_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       dac_on;
    logic       pwm_on;
    logic       done;
  } stat_t;

  // Centre at mid scale, double, saturate and offset back.
  function automatic logic [SMP_W-1:0] boost(input logic [SMP_W-1:0] s);
    logic [SMP_W:0] twice;
    twice = {s, 1'b0};
    if (s >= SMP_HI) begin
      return SMP_MAX;
    end else if (s < SMP_LO) begin
      return SMP_MIN;
    end else begin
      return SMP_W'(twice - {1'b0, SMP_MID});
    end
  endfunction

endpackage

// File: rtl/core/sample_player_dac_pwm.sv
// ----------------------------------------------------------------------------
// sample_player_dac_pwm
// Stored-sample player driving a DAC level or a PWM compare value.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the input queue has room and returns one
// result per item, in order. On its way to the result register, when the output
// side is ready, an accepted item leaves the four-entry input queue and reads
// the sample memory, is boosted and multiplied by the PWM period, then is scaled
// by 1/255 and registered as the result. Each sample memory has one read port,
// read whenever the back end advances. A full result register stalls the back end;
// the input queue keeps taking items until it fills. Configuration writes
// are taken in any cycle and should only be made while the block is idle.
module sample_player_dac_pwm (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  command_byte,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  player_mode,
  output logic        dac_enabled,
  output logic [11:0] dac_value,
  output logic        pwm_enabled,
  output logic [16:0] pwm_duty,
  output logic        finished
);
  import spdp_pkg::*;

  cfg_t    cfg;
  logic    q_valid;
  q_item_t q_head;
  logic    q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dac_length     <= '0;
      cfg.pwm_length     <= '0;
      cfg.carrier_period <= PERIOD_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DAC_LENGTH:     cfg.dac_length     <= cfg_data[LEN_W-1:0];
        REG_PWM_LENGTH:     cfg.pwm_length     <= cfg_data[LEN_W-1:0];
        REG_CARRIER_PERIOD: cfg.carrier_period <= cfg_data;
        default:            cfg.carrier_period <= cfg.carrier_period;
      endcase
    end
  end

  spdp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .command_byte (command_byte),
    .load_address (load_address),
    .load_sample  (load_sample),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  spdp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .player_mode (player_mode),
    .dac_enabled (dac_enabled),
    .dac_value   (dac_value),
    .pwm_enabled (pwm_enabled),
    .pwm_duty    (pwm_duty),
    .finished    (finished)
  );

  // The end of a table always leaves the player idle with both outputs off.
  a_finish_idles : assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> player_mode == MODE_IDLE && !dac_enabled && !pwm_enabled)
    else $error("finished result without a full stop");

  // Only one output path runs at a time.
  a_one_output : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(dac_enabled && pwm_enabled))
    else $error("DAC and PWM enabled together");

  // The enable flags follow the mode.
  a_mode_enable : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dac_enabled == (player_mode == MODE_DAC)
                  && pwm_enabled == (player_mode == MODE_PWM))
    else $error("enable flags disagree with player mode");

  // A result waiting for the consumer must not change.
  a_result_holds : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(dac_value) && $stable(pwm_duty)
                                && $stable(player_mode))
    else $error("stalled result changed");

endmodule

// File: rtl/core/spdp_ram.sv
// ----------------------------------------------------------------------------
// spdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/spdp_front.sv
// ----------------------------------------------------------------------------
// spdp_front
// Accepts input items, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
module spdp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               action,
  input  logic [7:0]               command_byte,
  input  logic [11:0]              load_address,
  input  logic [7:0]               load_sample,
  output logic                     q_valid,
  output spdp_pkg::q_item_t        q_head,
  input  logic                     q_pop
);
  import spdp_pkg::*;

  q_item_t           q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  op_t               op;
  logic              addr_ok;

  assign addr_ok = 32'(load_address) < SAMPLE_DEPTH;

  always_comb begin
    op = OP_NOP;
    unique case (action)
      ACT_TICK: begin
        op = OP_TICK;
      end
      ACT_CMD: begin
        unique case (command_byte) inside
          CMD_DAC:                  op = OP_PLAY_DAC;
          CMD_PWM:                  op = OP_PLAY_PWM;
          CMD_STOP_LO, CMD_STOP_UP: op = OP_STOP;
          default:                  op = OP_NOP;
        endcase
      end
      ACT_LOAD_DAC: begin
        op = addr_ok ? OP_LOAD_DAC : OP_NOP;
      end
      ACT_LOAD_PWM: begin
        op = addr_ok ? OP_LOAD_PWM : OP_NOP;
      end
      default: begin
        op = OP_NOP;
      end
    endcase
  end

  assign in_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = count != '0;
  assign pop      = q_pop && q_valid;
  assign q_head   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{op: op, addr: ADDR_W'(load_address), sample: load_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/spdp_back.sv
// ----------------------------------------------------------------------------
// spdp_back
// Executes queued operations: play control, sample memories, amplitude
// scaling and the result register.
// ----------------------------------------------------------------------------
module spdp_back (
  input  logic                      clk,
  input  logic                      rst,
  input  spdp_pkg::cfg_t            cfg,
  input  logic                      q_valid,
  input  spdp_pkg::q_item_t         q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                player_mode,
  output logic                      dac_enabled,
  output logic [11:0]               dac_value,
  output logic                      pwm_enabled,
  output logic [16:0]               pwm_duty,
  output logic                      finished
);
  import spdp_pkg::*;

  logic              advance;
  logic              take;

  // Play control state, updated as an item leaves the queue.
  logic [1:0]        mode;
  logic [1:0]        mode_next;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic              dac_on;
  logic              dac_on_next;
  logic              pwm_on;
  logic              pwm_on_next;
  logic              done;
  lvl_t              lvl;
  logic [31:0]       dac_limit;
  logic [31:0]       pwm_limit;
  logic              dac_we;
  logic              pwm_we;
  logic [SMP_W-1:0]  dac_rdata;
  logic [SMP_W-1:0]  pwm_rdata;

  logic              s1_valid;
  lvl_t              s1_lvl;
  stat_t             s1_stat;
  logic [SMP_W-1:0]  s1_smp;
  logic [SMP_W-1:0]  s1_amp;
  logic [PROD_W-1:0] s1_prod;

  logic              s2_valid;
  lvl_t              s2_lvl;
  stat_t             s2_stat;
  logic [SMP_W-1:0]  s2_amp;
  logic [PROD_W-1:0] s2_prod;
  logic [SCALED_W-1:0] s2_scaled;

  stat_t                out_stat;
  logic [LEVEL_W-1:0]   dac_level;
  logic [PERIOD_W-1:0]  pwm_compare;

  // The whole back end moves together whenever the result register is empty or being taken.
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance;
  assign take    = advance && q_valid;

  assign dac_limit = (32'(cfg.dac_length) > SAMPLE_DEPTH) ? 32'(SAMPLE_DEPTH)
                                                          : 32'(cfg.dac_length);
  assign pwm_limit = (32'(cfg.pwm_length) > SAMPLE_DEPTH) ? 32'(SAMPLE_DEPTH)
                                                          : 32'(cfg.pwm_length);

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    dac_on_next = dac_on;
    pwm_on_next = pwm_on;
    done        = 1'b0;
    lvl         = LVL_KEEP;
    dac_we      = 1'b0;
    pwm_we      = 1'b0;
    unique case (q_head.op)
      OP_TICK: begin
        if (mode == MODE_DAC || mode == MODE_PWM) begin
          if (32'(pos) >= ((mode == MODE_DAC) ? dac_limit : pwm_limit)) begin
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            dac_on_next = 1'b0;
            pwm_on_next = 1'b0;
            done        = 1'b1;
            lvl         = LVL_PARK;
          end else begin
            pos_next = pos + 1'b1;
            lvl      = (mode == MODE_DAC) ? LVL_DAC_SAMPLE : LVL_PWM_SAMPLE;
          end
        end
      end
      OP_PLAY_DAC: begin
        mode_next   = MODE_DAC;
        pos_next    = '0;
        dac_on_next = 1'b1;
        pwm_on_next = 1'b0;
        lvl         = LVL_PARK;
      end
      OP_PLAY_PWM: begin
        mode_next   = MODE_PWM;
        pos_next    = '0;
        dac_on_next = 1'b0;
        pwm_on_next = 1'b1;
        lvl         = LVL_PARK;
      end
      OP_STOP: begin
        mode_next   = MODE_IDLE;
        pos_next    = '0;
        dac_on_next = 1'b0;
        pwm_on_next = 1'b0;
        lvl         = LVL_PARK;
      end
      OP_LOAD_DAC: begin
        dac_we = 1'b1;
      end
      OP_LOAD_PWM: begin
        pwm_we = 1'b1;
      end
      default: begin
        lvl = LVL_KEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      dac_on <= 1'b0;
      pwm_on <= 1'b0;
    end else if (take) begin
      mode   <= mode_next;
      pos    <= pos_next;
      dac_on <= dac_on_next;
      pwm_on <= pwm_on_next;
    end
  end

  // A load and a later tick are separate items, so a write always lands
  // before the read that might want it.
  spdp_ram #(
    .WIDTH (SMP_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_dac_ram (
    .clk   (clk),
    .we    (take && dac_we),
    .waddr (q_head.addr),
    .wdata (q_head.sample),
    .re    (advance),
    .raddr (ADDR_W'(pos)),
    .rdata (dac_rdata)
  );

  spdp_ram #(
    .WIDTH (SMP_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_pwm_ram (
    .clk   (clk),
    .we    (take && pwm_we),
    .waddr (q_head.addr),
    .wdata (q_head.sample),
    .re    (advance),
    .raddr (ADDR_W'(pos)),
    .rdata (pwm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_lvl  <= lvl;
      s1_stat <= '{mode: mode_next, dac_on: dac_on_next, pwm_on: pwm_on_next,
                   done: done};
    end
  end

  assign s1_smp  = (s1_lvl == LVL_PWM_SAMPLE) ? pwm_rdata : dac_rdata;
  assign s1_amp  = boost(s1_smp);
  assign s1_prod = PROD_W'(s1_amp) * PROD_W'(cfg.carrier_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_lvl  <= s1_lvl;
      s2_stat <= s1_stat;
      s2_amp  <= s1_amp;
      s2_prod <= s1_prod;
    end
  end

  assign s2_scaled = SCALED_W'(s2_prod) * SCALED_W'(RECIP_255);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      out_stat    <= '0;
      dac_level   <= '0;
      pwm_compare <= '0;
    end else if (advance) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        out_stat <= s2_stat;
        unique case (s2_lvl)
          LVL_DAC_SAMPLE: dac_level   <= {s2_amp, 4'b0000};
          LVL_PWM_SAMPLE: pwm_compare <= s2_scaled[RECIP_SHIFT +: PERIOD_W];
          LVL_PARK:       dac_level   <= DAC_PARK;
          default:        dac_level   <= dac_level;
        endcase
      end
    end
  end

  assign player_mode = out_stat.mode;
  assign dac_enabled = out_stat.dac_on;
  assign pwm_enabled = out_stat.pwm_on;
  assign finished    = out_stat.done;
  assign dac_value   = dac_level;
  assign pwm_duty    = pwm_compare;

endmodule

// File: tb/sample_player_dac_pwm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_player_dac_pwm_tb
// Self-checking bench for the sample player. Items are offered from a queue,
// each accepted item is run through a behavioral player kept in the bench,
// and every result is compared field by field with the expected status.
// ----------------------------------------------------------------------------
module sample_player_dac_pwm_tb;
  import spdp_pkg::*;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int STALL_CYCLES  = 64;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 58;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    logic [1:0]        act;
    logic [7:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [SMP_W-1:0]  smp;
  } player_item_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic                dac_on;
    logic [LEVEL_W-1:0]  level;
    logic                pwm_on;
    logic [PERIOD_W-1:0] duty;
    logic                done;
  } player_status_t;

  typedef enum {PICK_TICK, PICK_LOAD, PICK_STOP, PICK_START, PICK_NOISE} pick_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [16:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          action = '0;
  logic [7:0]          command_byte = '0;
  logic [11:0]         load_address = '0;
  logic [7:0]          load_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          player_mode;
  logic                dac_enabled;
  logic [11:0]         dac_value;
  logic                pwm_enabled;
  logic [16:0]         pwm_duty;
  logic                finished;

  sample_player_dac_pwm dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Behavioral copy of the player, advanced once per accepted item.
  logic [1:0]          exp_mode = MODE_IDLE;
  logic [POS_W-1:0]    exp_pos = '0;
  logic [LEVEL_W-1:0]  exp_level = '0;
  logic                exp_dac_on = 1'b0;
  logic                exp_pwm_on = 1'b0;
  logic [PERIOD_W-1:0] exp_duty = '0;
  logic [SMP_W-1:0]    dac_table [SAMPLE_DEPTH];
  logic [SMP_W-1:0]    pwm_table [SAMPLE_DEPTH];
  logic [LEN_W-1:0]    dac_len_reg = '0;
  logic [LEN_W-1:0]    pwm_len_reg = '0;
  logic [PERIOD_W-1:0] period_reg = 17'd256;

  player_status_t expected_status [$];
  player_item_t   pending_items [$];
  player_item_t   next_item;
  player_status_t want;

  // Stimulus planning: tracks play position so no tick reads an empty entry.
  logic [1:0]       plan_mode = MODE_IDLE;
  logic [POS_W-1:0] plan_pos = '0;
  bit               dac_loaded [SAMPLE_DEPTH];
  bit               pwm_loaded [SAMPLE_DEPTH];

  logic in_took = 1'b0;
  int   idle_pct = 34;
  int   stall_asks = 0;
  int   stall_served = 0;
  int   stall_left = 0;
  int   items_queued = 0;
  int   counted_items = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   table_ends = 0;
  int   cfg_writes = 0;
  int   errors = 0;
  int   cycle_count = 0;

  function automatic logic [SMP_W-1:0] amplified(input logic [SMP_W-1:0] s);
    int c;
    c = 2 * (int'(s) - 128);
    if (c > 127) c = 127;
    else if (c < -128) c = -128;
    return SMP_W'(c + 128);
  endfunction

  function automatic logic [LEN_W-1:0] clipped(input logic [LEN_W-1:0] n);
    return (n > SAMPLE_DEPTH) ? LEN_W'(SAMPLE_DEPTH) : n;
  endfunction

  task automatic park_player();
    exp_mode   = MODE_IDLE;
    exp_pos    = '0;
    exp_level  = DAC_PARK;
    exp_dac_on = 1'b0;
    exp_pwm_on = 1'b0;
  endtask

  task automatic predict_player(input player_item_t it);
    player_status_t st;
    logic [SMP_W-1:0] amp;
    st.done = 1'b0;
    case (it.act)
      ACT_TICK: begin
        if (exp_mode == MODE_DAC || exp_mode == MODE_PWM) begin
          if (exp_pos >= clipped(exp_mode == MODE_DAC ? dac_len_reg : pwm_len_reg)) begin
            park_player();
            st.done = 1'b1;
          end else if (exp_mode == MODE_DAC) begin
            amp = amplified(dac_table[exp_pos[ADDR_W-1:0]]);
            exp_level = {amp, 4'h0};
            exp_pos = exp_pos + 1'b1;
          end else begin
            amp = amplified(pwm_table[exp_pos[ADDR_W-1:0]]);
            exp_duty = PERIOD_W'((32'(amp) * 32'(period_reg)) / 32'd255);
            exp_pos = exp_pos + 1'b1;
          end
        end
      end
      ACT_CMD: begin
        if (it.cmd == CMD_DAC) begin
          park_player();
          exp_mode   = MODE_DAC;
          exp_dac_on = 1'b1;
          exp_level  = DAC_PARK;
        end else if (it.cmd == CMD_PWM) begin
          park_player();
          exp_mode   = MODE_PWM;
          exp_pwm_on = 1'b1;
        end else if (it.cmd == CMD_STOP_LO || it.cmd == CMD_STOP_UP) begin
          park_player();
        end
      end
      ACT_LOAD_DAC: dac_table[it.addr] = it.smp;
      default:      pwm_table[it.addr] = it.smp;
    endcase
    st.mode   = exp_mode;
    st.dac_on = exp_dac_on;
    st.level  = exp_level;
    st.pwm_on = exp_pwm_on;
    st.duty   = exp_duty;
    expected_status.push_back(st);
  endtask

  task automatic compare_field(input string fname, input int unsigned exp_val,
                               input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", fname, exp_val, got_val);
      errors++;
    end
  endtask

  // Register writes and accepted items update the behavioral player.
  always @(posedge clk) begin
    in_took <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DAC_LENGTH:     dac_len_reg = cfg_data[LEN_W-1:0];
          REG_PWM_LENGTH:     pwm_len_reg = cfg_data[LEN_W-1:0];
          REG_CARRIER_PERIOD: period_reg  = cfg_data;
          default:            period_reg  = period_reg;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (in_valid && in_ready) begin
        predict_player({action, command_byte, load_address, load_sample});
        items_taken <= items_taken + 1;
      end
    end
  end

  // Sender: a held item stays on the port until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_item    = pending_items.pop_front();
        action       <= next_item.act;
        command_byte <= next_item.cmd;
        load_address <= next_item.addr;
        load_sample  <= next_item.smp;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with an occasional long hold-off so the input queue fills.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_served != stall_asks) begin
      stall_served <= stall_served + 1;
      stall_left   <= STALL_CYCLES;
      out_ready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_status.size() == 0) begin
        $error("result arrived with no item waiting for it");
        errors++;
      end else begin
        want = expected_status.pop_front();
        compare_field("player_mode", want.mode, player_mode);
        compare_field("dac_enabled", want.dac_on, dac_enabled);
        compare_field("dac_value", want.level, dac_value);
        compare_field("pwm_enabled", want.pwm_on, pwm_enabled);
        compare_field("pwm_duty", want.duty, pwm_duty);
        compare_field("finished", want.done, finished);
        if (finished) table_ends <= table_ends + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sample_player_dac_pwm_tb NOT OK");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] act, input logic [7:0] cmd,
                            input logic [ADDR_W-1:0] addr, input logic [SMP_W-1:0] smp);
    bit real_work;
    real_work = 1'b1;
    pending_items.push_back({act, cmd, addr, smp});
    items_queued++;
    case (act)
      ACT_TICK: begin
        if (plan_mode == MODE_IDLE) begin
          real_work = 1'b0;
        end else if (plan_pos >= clipped(plan_mode == MODE_DAC ? dac_len_reg
                                                               : pwm_len_reg)) begin
          plan_mode = MODE_IDLE;
          plan_pos  = '0;
        end else begin
          plan_pos = plan_pos + 1'b1;
        end
      end
      ACT_CMD: begin
        if (cmd == CMD_DAC || cmd == CMD_PWM) begin
          plan_mode = (cmd == CMD_DAC) ? MODE_DAC : MODE_PWM;
          plan_pos  = '0;
        end else if (cmd == CMD_STOP_LO || cmd == CMD_STOP_UP) begin
          plan_mode = MODE_IDLE;
          plan_pos  = '0;
        end else begin
          real_work = 1'b0;
        end
      end
      ACT_LOAD_DAC: dac_loaded[addr] = 1'b1;
      default:      pwm_loaded[addr] = 1'b1;
    endcase
    if (real_work) counted_items++;
  endtask

  // A tick that would read an entry never loaded gets that entry loaded first.
  task automatic queue_tick();
    logic [ADDR_W-1:0] slot;
    slot = plan_pos[ADDR_W-1:0];
    if (plan_mode == MODE_DAC && plan_pos < clipped(dac_len_reg) && !dac_loaded[slot])
      queue_item(ACT_LOAD_DAC, 8'($urandom_range(255)), slot, SMP_W'($urandom_range(255)));
    else if (plan_mode == MODE_PWM && plan_pos < clipped(pwm_len_reg) && !pwm_loaded[slot])
      queue_item(ACT_LOAD_PWM, 8'($urandom_range(255)), slot, SMP_W'($urandom_range(255)));
    queue_item(ACT_TICK, 8'($urandom_range(255)), ADDR_W'($urandom_range(4095)),
               SMP_W'($urandom_range(255)));
  endtask

  task automatic queue_random_item();
    int    roll;
    pick_t pick;
    roll = $urandom_range(99);
    if (plan_mode != MODE_IDLE)
      pick = roll < 75 ? PICK_TICK : roll < 85 ? PICK_LOAD : roll < 90 ? PICK_STOP :
             roll < 95 ? PICK_START : PICK_NOISE;
    else
      pick = roll < 60 ? PICK_START : roll < 75 ? PICK_LOAD : roll < 90 ? PICK_TICK :
             roll < 95 ? PICK_STOP : PICK_NOISE;
    case (pick)
      PICK_TICK: queue_tick();
      PICK_LOAD: begin
        // Mostly low addresses, where playback reads, now and then anywhere.
        queue_item($urandom_range(1) ? ACT_LOAD_DAC : ACT_LOAD_PWM, 8'($urandom_range(255)),
                   ADDR_W'($urandom_range(7) == 0 ? $urandom_range(4095) : $urandom_range(31)),
                   SMP_W'($urandom_range(255)));
      end
      PICK_STOP:
        queue_item(ACT_CMD, $urandom_range(1) ? CMD_STOP_LO : CMD_STOP_UP,
                   ADDR_W'($urandom_range(4095)), SMP_W'($urandom_range(255)));
      PICK_START:
        queue_item(ACT_CMD, $urandom_range(1) ? CMD_DAC : CMD_PWM,
                   ADDR_W'($urandom_range(4095)), SMP_W'($urandom_range(255)));
      default:
        queue_item(ACT_CMD, 8'($urandom_range(255)), ADDR_W'($urandom_range(4095)),
                   SMP_W'($urandom_range(255)));
    endcase
  endtask

  function automatic logic [LEN_W-1:0] pick_length(input int phase);
    case (phase)
      0: return LEN_W'(SAMPLE_DEPTH);
      1: return '1;
      2: return '0;
      default: begin
        case ($urandom_range(7))
          0:       return '0;
          1:       return LEN_W'(SAMPLE_DEPTH);
          2:       return LEN_W'($urandom_range(SAMPLE_DEPTH + 1, 8191));
          default: return LEN_W'($urandom_range(1, 20));
        endcase
      end
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period(input int phase);
    case (phase)
      0: return '0;
      1: return '1;
      2: return 17'd1;
      default: begin
        case ($urandom_range(5))
          0:       return 17'd256;
          1:       return 17'd65536;
          2:       return 17'd255;
          3:       return PERIOD_W'($urandom_range(131071));
          default: return PERIOD_W'($urandom_range(256, 65536));
        endcase
      end
    endcase
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: lengths are zero, so each start ends on its first tick.
    queue_tick();
    queue_item(ACT_CMD, 8'h00, '0, '0);
    queue_item(ACT_CMD, CMD_STOP_LO, '0, '0);
    queue_item(ACT_CMD, CMD_DAC, '0, '0);
    queue_tick();
    queue_item(ACT_CMD, CMD_PWM, '0, '0);
    queue_tick();
    queue_item(ACT_CMD, CMD_STOP_UP, '1, '1);
    wait_drained();

    write_register(REG_DAC_LENGTH, 17'd3);
    write_register(REG_PWM_LENGTH, 17'd3);
    write_register(REG_CARRIER_PERIOD, 17'd65536);
    @(posedge clk);
    // Saturation at both ends, silence, and the top address.
    queue_item(ACT_LOAD_DAC, '0, 12'd0, 8'd0);
    queue_item(ACT_LOAD_DAC, '0, 12'd1, 8'd255);
    queue_item(ACT_LOAD_DAC, '0, 12'd2, 8'd128);
    queue_item(ACT_LOAD_DAC, '0, 12'd4095, 8'hAA);
    queue_item(ACT_LOAD_PWM, '0, 12'd0, 8'd255);
    queue_item(ACT_LOAD_PWM, '0, 12'd1, 8'd100);
    queue_item(ACT_LOAD_PWM, '0, 12'd2, 8'd63);
    queue_item(ACT_CMD, CMD_DAC, '0, '0);
    repeat (4) queue_tick();
    queue_item(ACT_CMD, CMD_PWM, '0, '0);
    repeat (2) queue_tick();
    queue_item(ACT_CMD, CMD_DAC, '0, '0);
    queue_item(ACT_CMD, CMD_STOP_LO, '0, '0);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_register(REG_DAC_LENGTH, 17'(pick_length(phase)));
      write_register(REG_PWM_LENGTH, 17'(pick_length(phase + 1)));
      write_register(REG_CARRIER_PERIOD, pick_period(phase));
      @(posedge clk);
      idle_pct = (phase == 4 || phase == 5) ? 0 : 34;
      if (phase == 2 || phase == 7) stall_asks++;
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) queue_random_item();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d expected results never arrived", expected_status.size());
      errors++;
    end
    $display("Played %0d items through DAC and PWM modes, %0d results checked.",
             items_taken, results_seen);
    $display("Saw %0d table ends across %0d register writes.", table_ends, cfg_writes);
    if (errors == 0) begin
      $display("sample_player_dac_pwm_tb OK");
    end else begin
      $display("sample_player_dac_pwm_tb NOT OK");
    end
    $finish;
  end

endmodule
